/* rtl/udp_frame_filter_extract_core_assert.svh */
// Assertion macros shared by the frame filter checker
`ifndef UDP_FRAME_FILTER_EXTRACT_CORE_ASSERT_SVH
`define UDP_FRAME_FILTER_EXTRACT_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define UFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame filter check failed in the same cycle");

// next-cycle implication, disabled while reset is asserted
`define UFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame filter check failed one cycle later");

`endif

/* rtl/ufe_pkg.sv */
// Types and constants for the Ethernet/IPv4/UDP frame filter
`timescale 1ns / 1ps

package ufe_pkg;

	// result status codes
	typedef enum logic [2:0] {
		ST_ACCEPT       = 3'd0,
		ST_MAC_FILTERED = 3'd1,
		ST_NOT_IPV4     = 3'd2,
		ST_NOT_UDP      = 3'd3,
		ST_TOO_SHORT    = 3'd4
	} ufe_status_t;

	// one result request
	typedef struct packed {
		ufe_status_t status;
		logic [63:0] payload;
	} ufe_result_t;

	// frame byte offsets (byte count before the current byte)
	localparam logic [5:0] MAC_LEN     = 6'd6;
	localparam logic [5:0] ETYPE_OFF   = 6'd12;
	localparam logic [5:0] ETYPE_OFF_1 = 6'd13;
	localparam logic [5:0] PROTO_OFF   = 6'd23;
	localparam logic [5:0] PAYLOAD_OFF = 6'd42;
	localparam logic [5:0] PAYLOAD_END = 6'd50;
	localparam logic [5:0] OFFSET_MAX  = 6'd63;

	// header values
	localparam logic [7:0] BCAST_BYTE   = 8'hff;
	localparam logic [7:0] ETYPE_IPV4_H = 8'h08;
	localparam logic [7:0] ETYPE_IPV4_L = 8'h00;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;

	// configuration register indexes
	localparam logic REG_OWN_MAC   = 1'b0;
	localparam logic REG_FILTER_EN = 1'b1;

endpackage

/* rtl/ufe_stream_if.sv */
// Valid/ready stream interfaces for frame bytes and filter results
`timescale 1ns / 1ps

interface ufe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface ufe_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] payload_value;

	modport source (output valid, output status, output payload_value, input ready);
	modport sink (input valid, input status, input payload_value, output ready);
endinterface

/* rtl/ufe_frame_parser.sv */
// Per-byte header tracking and status decision for one frame
`timescale 1ns / 1ps

module ufe_frame_parser import ufe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	input  logic [47:0] own_mac,
	input  logic        filter_enable,
	output ufe_result_t result
);

	logic [5:0]  offset_q;
	logic        ucast_q;
	logic        bcast_q;
	logic        etype_ok_q;
	logic        proto_ok_q;
	logic [63:0] pay_q;

	logic [7:0]  mac_want;
	logic        in_mac;
	logic        ucast_d;
	logic        bcast_d;
	logic        etype_ok_d;
	logic        proto_ok_d;
	logic [63:0] pay_d;
	logic        filtered;

	// own MAC byte expected at this offset, first wire byte is the top one
	always_comb begin
		case (offset_q[2:0])
			3'd0:    mac_want = own_mac[47:40];
			3'd1:    mac_want = own_mac[39:32];
			3'd2:    mac_want = own_mac[31:24];
			3'd3:    mac_want = own_mac[23:16];
			3'd4:    mac_want = own_mac[15:8];
			default: mac_want = own_mac[7:0];
		endcase
	end

	// flag updates for the byte in hand
	always_comb begin
		in_mac     = offset_q < MAC_LEN;
		ucast_d    = ucast_q & (!in_mac | (frame_byte == mac_want));
		bcast_d    = bcast_q & (!in_mac | (frame_byte == BCAST_BYTE));
		etype_ok_d = etype_ok_q;
		if (offset_q == ETYPE_OFF && frame_byte != ETYPE_IPV4_H) begin
			etype_ok_d = 1'b0;
		end
		if (offset_q == ETYPE_OFF_1 && frame_byte != ETYPE_IPV4_L) begin
			etype_ok_d = 1'b0;
		end
		proto_ok_d = (offset_q == PROTO_OFF) ? (frame_byte == IP_PROTO_UDP) : proto_ok_q;
		pay_d = pay_q;
		if (offset_q >= PAYLOAD_OFF && offset_q < PAYLOAD_END) begin
			pay_d = {frame_byte, pay_q[63:8]};
		end
	end

	// status priority; length L = offset + 1, so L < n is offset < n - 1
	always_comb begin
		filtered = filter_enable & !ucast_d & !bcast_d;
		result.payload = 64'd0;
		if (offset_q < MAC_LEN - 6'd1) begin
			result.status = ST_TOO_SHORT;
		end else if (filtered) begin
			result.status = ST_MAC_FILTERED;
		end else if (offset_q < ETYPE_OFF_1) begin
			result.status = ST_TOO_SHORT;
		end else if (!etype_ok_d) begin
			result.status = ST_NOT_IPV4;
		end else if (offset_q < PROTO_OFF) begin
			result.status = ST_TOO_SHORT;
		end else if (!proto_ok_d) begin
			result.status = ST_NOT_UDP;
		end else if (offset_q < PAYLOAD_END - 6'd1) begin
			result.status = ST_TOO_SHORT;
		end else begin
			result.status  = ST_ACCEPT;
			result.payload = pay_d;
		end
	end

	// frame state: advance on each byte, back to start after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= 6'd0;
			ucast_q    <= 1'b1;
			bcast_q    <= 1'b1;
			etype_ok_q <= 1'b1;
			proto_ok_q <= 1'b0;
			pay_q      <= 64'd0;
		end else if (take) begin
			if (last_byte) begin
				offset_q   <= 6'd0;
				ucast_q    <= 1'b1;
				bcast_q    <= 1'b1;
				etype_ok_q <= 1'b1;
				proto_ok_q <= 1'b0;
				pay_q      <= 64'd0;
			end else begin
				if (offset_q != OFFSET_MAX) begin
					offset_q <= offset_q + 6'd1;
				end
				ucast_q    <= ucast_d;
				bcast_q    <= bcast_d;
				etype_ok_q <= etype_ok_d;
				proto_ok_q <= proto_ok_d;
				pay_q      <= pay_d;
			end
		end
	end

endmodule

/* rtl/udp_frame_filter_extract_core.sv */
// Top level of the Ethernet/IPv4/UDP frame filter and payload extractor
// Usage:
//   frame_in carries one frame byte per request, wire order, last_byte on the
//   final byte. result_out carries one status request per frame, raised the
//   cycle after the last byte is taken unless stalled; payload_value holds
//   the first eight UDP payload bytes (first byte in bits 7:0) if accepted.
//   Throughput is one byte per cycle: header checks are a few byte compares
//   done between the frame state registers and the result register.
//   The APB port holds own_mac (address 0) and filter_enable (address 8);
//   write them only while no frame is in progress. pready is always high.
//   Reset clears the frame state, both config registers and the result stage.
//   When result_out stalls, a second result is held in a skid register and
//   frame_in keeps taking bytes; only with both result slots full does
//   frame_in.ready drop, and it rises again once result_out takes one.
`timescale 1ns / 1ps

module udp_frame_filter_extract_core import ufe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ufe_byte_if.sink     frame_in,
	ufe_result_if.source result_out,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	logic [47:0] own_mac_q;
	logic        filter_en_q;
	logic        cfg_wr;

	logic        take;
	logic        res_new;
	ufe_result_t res_d;

	logic        out_valid_q;
	ufe_result_t out_q;
	logic        skid_valid_q;
	ufe_result_t skid_q;

	// configuration writes, decoded on the 8-byte register slot
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q   <= 48'd0;
			filter_en_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3])
				REG_OWN_MAC:   own_mac_q   <= pwdata[47:0];
				REG_FILTER_EN: filter_en_q <= pwdata[0];
				default:       ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3])
			REG_OWN_MAC:   prdata = {16'd0, own_mac_q};
			REG_FILTER_EN: prdata = {63'd0, filter_en_q};
			default:       prdata = 64'd0;
		endcase
	end

	// byte acceptance
	assign frame_in.ready = !skid_valid_q;
	assign take           = frame_in.valid & frame_in.ready;
	assign res_new        = take & frame_in.last_byte;

	ufe_frame_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.frame_byte    (frame_in.frame_byte),
		.last_byte     (frame_in.last_byte),
		.own_mac       (own_mac_q),
		.filter_enable (filter_en_q),
		.result        (res_d)
	);

	// result register with a skid slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (result_out.ready || !out_valid_q) begin
			out_valid_q  <= skid_valid_q | res_new;
			skid_valid_q <= 1'b0;
		end else if (res_new) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (result_out.ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res_d;
		end else if (res_new) begin
			skid_q <= res_d;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.status        = out_q.status;
	assign result_out.payload_value = out_q.payload;

endmodule

/* rtl/ufe_checker.sv */
// Port-level checker for the frame filter, bound to the top level
`timescale 1ns / 1ps
`include "udp_frame_filter_extract_core_assert.svh"

module ufe_checker import ufe_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  out_status,
	input logic [63:0] out_payload
);

	// a stalled result stays up
	`UFE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// a stalled result keeps its payload
	`UFE_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_status) && $stable(out_payload))

	// payload is zero for any rejected frame
	`UFE_ASSERT_SAME(a_pay_zero, clk, arst_n, out_valid && out_status != ST_ACCEPT, out_payload == 64'd0)

	// status stays within the defined codes
	`UFE_ASSERT_SAME(a_status_range, clk, arst_n, out_valid, out_status <= ST_TOO_SHORT)

	// a last byte taken with the output empty shows a result next cycle
	`UFE_ASSERT_NEXT(a_last_result, clk, arst_n, in_valid && in_ready && in_last && !out_valid, out_valid)

endmodule

bind udp_frame_filter_extract_core ufe_checker u_ufe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (frame_in.valid),
	.in_ready    (frame_in.ready),
	.in_last     (frame_in.last_byte),
	.out_valid   (result_out.valid),
	.out_ready   (result_out.ready),
	.out_status  (result_out.status),
	.out_payload (result_out.payload_value)
);

/* tb/sv/ufe_frame_checker.sv */
// Scoreboard for the frame filter: predicts one status result per frame and checks it
`timescale 1ns / 1ps

module ufe_frame_checker import ufe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ufe_byte_if         frame_mon,
	ufe_result_if       result_mon,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending,
	output int          results_checked
);

	// shadow copy of the registers
	logic [47:0] own_mac_q;
	logic        filter_en_q;

	// predicted frame parse state
	logic [5:0]  byte_offset;
	logic        unicast_match;
	logic        broadcast_match;
	logic        ethertype_ok;
	logic        protocol_ok;
	logic [63:0] payload_shift;

	// status results still owed by the block, oldest first
	ufe_result_t expected_results[$];

	task automatic clear_frame_state();
		byte_offset     = '0;
		unicast_match   = 1'b1;
		broadcast_match = 1'b1;
		ethertype_ok    = 1'b1;
		protocol_ok     = 1'b0;
		payload_shift   = '0;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("@%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// header compare / payload capture for one byte; status on the last byte
	task automatic parse_frame_byte(input logic [7:0] data, input logic last);
		logic [5:0]  off;
		int          sel;
		int          len;
		ufe_status_t st;
		ufe_result_t res;
		off = byte_offset;
		if (off < MAC_LEN) begin
			sel = 8 * (5 - int'(off));
			if (data != own_mac_q[sel +: 8])
				unicast_match = 1'b0;
			if (data != BCAST_BYTE)
				broadcast_match = 1'b0;
		end else if (off == ETYPE_OFF) begin
			if (data != ETYPE_IPV4_H)
				ethertype_ok = 1'b0;
		end else if (off == ETYPE_OFF_1) begin
			if (data != ETYPE_IPV4_L)
				ethertype_ok = 1'b0;
		end else if (off == PROTO_OFF) begin
			protocol_ok = (data == IP_PROTO_UDP);
		end else if (off >= PAYLOAD_OFF && off < PAYLOAD_END) begin
			payload_shift = {data, payload_shift[63:8]};
		end
		// offset saturates so long frames never wrap
		if (byte_offset < OFFSET_MAX)
			byte_offset++;
		if (last) begin
			// first failing rule in frame order wins
			len = int'(off) + 1;
			if (len < int'(MAC_LEN))
				st = ST_TOO_SHORT;
			else if (filter_en_q && !unicast_match && !broadcast_match)
				st = ST_MAC_FILTERED;
			else if (len < int'(ETYPE_OFF_1) + 1)
				st = ST_TOO_SHORT;
			else if (!ethertype_ok)
				st = ST_NOT_IPV4;
			else if (len < int'(PROTO_OFF) + 1)
				st = ST_TOO_SHORT;
			else if (!protocol_ok)
				st = ST_NOT_UDP;
			else if (len < int'(PAYLOAD_END))
				st = ST_TOO_SHORT;
			else
				st = ST_ACCEPT;
			res.status  = st;
			res.payload = (st == ST_ACCEPT) ? payload_shift : '0;
			expected_results.push_back(res);
			clear_frame_state();
		end
	endtask

	task automatic check_result(input logic [2:0] status, input logic [63:0] payload);
		ufe_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected result status", 64'(status), '0);
			return;
		end
		want = expected_results.pop_front();
		results_checked++;
		if (status != want.status)
			report_mismatch("status", 64'(status), 64'(want.status));
		if (payload != want.payload)
			report_mismatch("payload_value", payload, want.payload);
	endtask

	// registers sit at 8-byte strides
	task automatic apply_reg_write(input logic [3:0] addr, input logic [63:0] data);
		if (addr[2:0] == 3'd0) begin
			if (addr[3] == REG_OWN_MAC)
				own_mac_q = data[47:0];
			else if (addr[3] == REG_FILTER_EN)
				filter_en_q = data[0];
		end
	endtask

	// result compared before the byte so a same-edge push is never popped early
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q       = '0;
			filter_en_q     = 1'b0;
			clear_frame_state();
			expected_results.delete();
			mismatches      = 0;
			results_checked = 0;
		end else begin
			if (result_mon.valid && result_mon.ready)
				check_result(result_mon.status, result_mon.payload_value);
			if (frame_mon.valid && frame_mon.ready)
				parse_frame_byte(frame_mon.frame_byte, frame_mon.last_byte);
			if (psel && penable && pwrite && pready)
				apply_reg_write(paddr, pwdata);
		end
		pending = expected_results.size();
	end

endmodule

/* tb/sv/tb_udp_frame_filter_extract_core.sv */
// Testbench top for the frame filter: clock, reset, frame and register stimulus, verdict
`timescale 1ns / 1ps

module tb_udp_frame_filter_extract_core;
	import ufe_pkg::*;

	localparam int          RANDOM_BYTES   = 600;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam logic [3:0]  ADDR_OWN_MAC   = {REG_OWN_MAC, 3'b000};
	localparam logic [3:0]  ADDR_FILTER_EN = {REG_FILTER_EN, 3'b000};
	localparam logic [15:0] ETYPE_IPV4     = {ETYPE_IPV4_H, ETYPE_IPV4_L};
	localparam logic [15:0] ETYPE_IPV6     = 16'h86dd;
	localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
	localparam logic [47:0] MAC_BCAST      = 48'hffff_ffff_ffff;
	localparam logic [47:0] MAC_A          = 48'h02_1a_3c_4d_5e_6f;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	int          mismatches;
	int          pending;
	int          results_checked;

	bit          send_no_idle;
	bit          recv_no_idle;
	bit          hold_req;
	int          bytes_sent;
	int          frames_sent;
	int          settings_used;
	int          long_holds;
	logic [47:0] cur_own_mac;

	ufe_byte_if   frame_if ();
	ufe_result_if result_if ();

	udp_frame_filter_extract_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_if),
		.result_out (result_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	ufe_frame_checker u_status_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.frame_mon       (frame_if),
		.result_mon      (result_if),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// all drivers below run on the falling edge
	task automatic send_byte(input logic [7:0] data, input logic last);
		int gap;
		gap = send_no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			frame_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_if.valid      <= 1'b1;
		frame_if.frame_byte <= data;
		frame_if.last_byte  <= last;
		do @(posedge clk); while (!frame_if.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// header fields at their wire offsets, filler bytes random
	task automatic send_frame(input logic [47:0] dst, input logic [15:0] etype,
		input logic [7:0] proto, input int len, input logic [63:0] payload);
		logic [7:0] data;
		for (int i = 0; i < len; i++) begin
			data = 8'($urandom_range(0, 255));
			if (i < 6)
				data = dst[8 * (5 - i) +: 8];
			else if (i == 12)
				data = etype[15:8];
			else if (i == 13)
				data = etype[7:0];
			else if (i == 23)
				data = proto;
			else if (i >= 42 && i < 50)
				data = payload[8 * (i - 42) +: 8];
			send_byte(data, i == len - 1);
		end
		frames_sent++;
	endtask

	// mostly well-formed UDP frames, the rest with bad fields, short or long
	task automatic random_frame();
		logic [47:0] dst;
		logic [15:0] etype;
		logic [7:0]  proto;
		logic [63:0] r64;
		int          len;
		int          pick;
		r64  = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick < 4)
			dst = cur_own_mac;
		else if (pick < 6)
			dst = MAC_BCAST;
		else if (pick < 8)
			dst = r64[47:0];
		else
			dst = cur_own_mac ^ (48'h1 << $urandom_range(0, 47));
		pick = $urandom_range(0, 9);
		if (pick < 8)
			etype = ETYPE_IPV4;
		else if (pick == 8)
			etype = 16'($urandom);
		else
			etype = ETYPE_IPV4 ^ (16'h1 << $urandom_range(0, 15));
		proto = ($urandom_range(0, 9) < 8) ? IP_PROTO_UDP : 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 19);
		if (pick < 14)
			len = $urandom_range(50, 64);
		else if (pick < 19)
			len = $urandom_range(1, 49);
		else
			len = $urandom_range(65, 120);
		r64 = {$urandom, $urandom};
		send_frame(dst, etype, proto, len, r64);
	endtask

	// setup then access; caller drops psel after the last write
	task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	// wait until every owed result is out
	task automatic settle();
		frame_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(negedge clk);
	endtask

	// unused upper data bits carry junk to check the register masks
	task automatic set_config(input logic [47:0] mac, input logic filt);
		settle();
		write_reg(ADDR_OWN_MAC, {16'($urandom), mac});
		write_reg(ADDR_FILTER_EN, {63'($urandom) << 1, filt} );
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_own_mac = mac;
		settings_used++;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int stall;
		result_if.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				result_if.ready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_holds++;
			end
			stall = recv_no_idle ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			@(negedge clk);
		end
	end

	// ends the run when no request moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready) ||
				(psel && penable && pwrite && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("udp_frame_filter_extract_core verification failed");
		$finish;
	end

	initial begin : stimulus
		int rand_start;
		bit pressure_done;
		frame_if.valid      = 1'b0;
		frame_if.frame_byte = '0;
		frame_if.last_byte  = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		send_no_idle        = 1'b0;
		recv_no_idle        = 1'b0;
		hold_req            = 1'b0;
		bytes_sent          = 0;
		frames_sent         = 0;
		settings_used       = 0;
		long_holds          = 0;
		cur_own_mac         = '0;
		pressure_done       = 1'b0;
		arst_n              = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: filter off
		send_frame(MAC_BCAST, ETYPE_IPV4, IP_PROTO_UDP, 1, '0);
		send_frame(48'h5a_00_12_34_56_78, ETYPE_IPV4, IP_PROTO_UDP, 50, '0);

		// filter on: every status and each length boundary
		set_config(MAC_A, 1'b1);
		send_frame(MAC_A, ETYPE_IPV4, IP_PROTO_UDP, 50, 64'hffff_ffff_ffff_ffff);
		send_frame(MAC_BCAST, ETYPE_IPV4, IP_PROTO_UDP, 50, 64'h0123_4567_89ab_cdef);
		send_frame(MAC_A ^ 48'h1, ETYPE_IPV4, IP_PROTO_UDP, 50, '1);
		send_frame(MAC_A ^ 48'h80_0000_0000, ETYPE_IPV4, IP_PROTO_UDP, 5, '1);
		send_frame(MAC_A ^ 48'h80_0000_0000, ETYPE_IPV4, IP_PROTO_UDP, 6, '1);
		send_frame(MAC_A, ETYPE_IPV6, IP_PROTO_UDP, 50, '1);
		send_frame(MAC_A, ETYPE_IPV4 ^ 16'h0001, IP_PROTO_UDP, 50, '1);
		send_frame(MAC_A, ETYPE_IPV4 ^ 16'h0100, IP_PROTO_UDP, 50, '1);
		send_frame(MAC_A, ETYPE_IPV4, IP_PROTO_TCP, 50, '1);
		send_frame(MAC_A, ETYPE_IPV4, IP_PROTO_UDP, 13, '1);
		send_frame(MAC_A, ETYPE_IPV4, IP_PROTO_UDP, 14, '1);
		send_frame(MAC_A, ETYPE_IPV4, IP_PROTO_UDP, 23, '1);
		send_frame(MAC_A, ETYPE_IPV4, IP_PROTO_TCP, 24, '1);
		send_frame(MAC_A, ETYPE_IPV4, IP_PROTO_UDP, 49, '1);
		// long frame, offset saturates
		send_frame(MAC_A, ETYPE_IPV4, IP_PROTO_UDP, 100, 64'h8000_0000_0000_0001);

		// own MAC equal to broadcast, then all zeros with filter off
		set_config(MAC_BCAST, 1'b1);
		send_frame(MAC_BCAST, ETYPE_IPV4, IP_PROTO_UDP, 50, 64'h00ff_00ff_00ff_00ff);
		send_frame('0, ETYPE_IPV4, IP_PROTO_UDP, 50, '1);
		set_config('0, 1'b0);
		send_frame(MAC_A, ETYPE_IPV4, IP_PROTO_UDP, 50, 64'hdead_beef_cafe_f00d);
		send_frame(MAC_A, ETYPE_IPV4, 8'hff, 50, '1);

		// random phases, each under fresh register settings and idle pattern;
		// the loop keeps going until the long hold-off has been run once
		rand_start = bytes_sent;
		while (bytes_sent - rand_start < RANDOM_BYTES || !pressure_done) begin
			case ($urandom_range(0, 9))
				0: set_config('0, 1'($urandom_range(0, 1)));
				1: set_config(MAC_BCAST, 1'($urandom_range(0, 1)));
				default: set_config(48'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
			endcase
			send_no_idle = ($urandom_range(0, 3) == 0);
			recv_no_idle = ($urandom_range(0, 3) == 0);
			// back-pressure: result side holds off while short frames keep coming
			if (!pressure_done && bytes_sent - rand_start > RANDOM_BYTES / 2) begin
				hold_req     = 1'b1;
				send_no_idle = 1'b1;
				repeat (20)
					send_frame(48'({$urandom, $urandom}), 16'($urandom), 8'($urandom),
						$urandom_range(1, 4), '0);
				pressure_done = 1'b1;
				send_no_idle  = 1'b0;
			end
			repeat ($urandom_range(3, 7))
				random_frame();
		end
		settle();

		$display("Run covered %0d frames, %0d bytes and %0d checked results over %0d register settings.",
			frames_sent, bytes_sent, results_checked, settings_used);
		$display("Result side held off %0d time(s) for %0d cycles while bytes kept arriving.",
			long_holds, HOLD_CYCLES);
		if (mismatches == 0)
			$display("udp_frame_filter_extract_core verification clean");
		else
			$display("udp_frame_filter_extract_core verification failed");
		$finish;
	end

endmodule
